@@ hw/rtl/pps_pkg.sv @@
package pps_pkg;

  localparam int CountLimitDefault = 127;

  typedef enum logic [1:0] {
    KIND_FRONT  = 2'd0,
    KIND_BACK   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;

  // Classified vertex handed from front to back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [63:0] side;
    logic               last;
  } vtx_t;

  // Signed 64-bit add that saturates
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) sat_add64 = {1'b0, {63{1'b1}}};
    else if (a[63] && b[63] && !s[63]) sat_add64 = {1'b1, 63'd0};
    else sat_add64 = s;
  endfunction

endpackage

@@ hw/rtl/pps_front.sv @@
// Side value of each vertex: one product per cycle, accumulated with saturation.
module pps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   vert_x,
  input  logic signed [31:0]   vert_y,
  input  logic signed [31:0]   vert_z,
  input  logic                 last_vertex,
  input  logic signed [31:0]   pa,
  input  logic signed [31:0]   pb,
  input  logic signed [31:0]   pc,
  input  logic signed [31:0]   pd,
  output logic                 q_valid,
  input  logic                 q_ready,
  output pps_pkg::vtx_t        q_data
);
  import pps_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MA, F_MB, F_MC, F_MD, F_SUM, F_OUT} fstate_t;

  fstate_t            state;
  vtx_t               v;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] op_p, op_v;

  assign in_stall = (state != F_IDLE);
  assign q_valid  = (state == F_OUT);
  assign q_data   = v;

  // Select operands for this cycle's product
  always_comb begin
    unique case (state)
      F_MA:    begin op_p = pa; op_v = v.x; end
      F_MB:    begin op_p = pb; op_v = v.y; end
      F_MC:    begin op_p = pc; op_v = v.z; end
      default: begin op_p = pd; op_v = 32'sd65536; end
    endcase
  end

  // Hold state, product and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) begin
          v.x    <= vert_x;
          v.y    <= vert_y;
          v.z    <= vert_z;
          v.last <= last_vertex;
          state  <= F_MA;
        end
        F_MA: begin
          prod  <= op_p * op_v;
          state <= F_MB;
        end
        F_MB: begin
          acc   <= prod;
          prod  <= op_p * op_v;
          state <= F_MC;
        end
        F_MC: begin
          acc   <= sat_add64(acc, prod);
          prod  <= op_p * op_v;
          state <= F_MD;
        end
        F_MD: begin
          acc   <= sat_add64(acc, prod);
          prod  <= op_p * op_v;
          state <= F_SUM;
        end
        // Add the offset term last
        F_SUM: begin
          v.side <= sat_add64(acc, prod);
          state  <= F_OUT;
        end
        F_OUT: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pps_queue.sv @@
// Two-entry queue between classifier and splitter.
module pps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pps_pkg::vtx_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output pps_pkg::vtx_t  rd_data
);
  import pps_pkg::*;

  vtx_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  // Advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data;
        wp      <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

@@ hw/rtl/pps_back.sv @@
// Splitter: emits vertices, intersections and the status item.
module pps_back #(
  parameter int COUNT_LIMIT = pps_pkg::CountLimitDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  pps_pkg::vtx_t       q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [6:0]          front_count,
  output logic [6:0]          back_count,
  output logic                front_kept,
  output logic                back_kept,
  output logic                end_of_run
);
  import pps_pkg::*;

  localparam int CW = $clog2(COUNT_LIMIT + 1);
  localparam logic [CW-1:0] Lim = CW'(COUNT_LIMIT);

  typedef enum logic [3:0] {
    B_IDLE, B_DECIDE, B_SHIFT, B_DIV, B_MUL, B_MUL2, B_EMIT, B_NEXT
  } bstate_t;

  bstate_t            state;
  vtx_t               cur;
  logic signed [31:0] fx, fy, fz, px, py, pz;
  logic signed [63:0] fside, pside;
  logic               first_pend;
  logic [CW-1:0]      fcnt, bcnt;

  // Emission script, up to six entries
  logic [2:0]         op_idx, op_num;
  logic [2:0]         ops [6];

  localparam logic [2:0] OP_CF = 3'd0; // current front
  localparam logic [2:0] OP_CB = 3'd1; // current back
  localparam logic [2:0] OP_IF = 3'd2; // intersection front
  localparam logic [2:0] OP_IB = 3'd3; // intersection back
  localparam logic [2:0] OP_ST = 3'd4; // status
  localparam logic [2:0] OP_CL = 3'd5; // start closing intersection

  // Intersection unit operands
  logic signed [31:0] bx, by, bz, ox, oy, oz;
  logic [63:0]        mb, mo;
  logic [31:0]        den;
  logic [30:0]        tq;
  logic [62:0]        rem;
  logic [4:0]         dcnt;
  logic [1:0]         axis;
  logic signed [31:0] ix, iy, iz;
  logic [32:0]        dmag;
  logic               dneg;
  logic [63:0]        mprod;

  function automatic logic [63:0] mag64(input logic signed [63:0] s);
    mag64 = s[63] ? (64'd0 - 64'(s)) : 64'(s);
  endfunction

  function automatic logic opp(input logic signed [63:0] a, input logic signed [63:0] b);
    opp = (a != 0) && (b != 0) && (a[63] != b[63]);
  endfunction

  logic signed [31:0] bsel, osel;
  logic signed [32:0] diff;
  logic signed [34:0] rsum;
  logic signed [31:0] rsat;

  always_comb begin
    case (axis)
      2'd0:    begin bsel = bx; osel = ox; end
      2'd1:    begin bsel = by; osel = oy; end
      default: begin bsel = bz; osel = oz; end
    endcase
    diff = 33'(osel) - 33'(bsel);
    rsum = dneg ? (35'(bsel) - 35'({1'b0, mprod[63:30]} + 35'(mprod[29])))
                : (35'(bsel) + 35'({1'b0, mprod[63:30]} + 35'(mprod[29])));
    if (rsum > 35'sd2147483647) rsat = 32'h7fffffff;
    else if (rsum < -35'sd2147483648) rsat = 32'h80000000;
    else rsat = rsum[31:0];
  end

  assign q_ready = (state == B_IDLE);

  logic [2:0] op;
  assign op = ops[op_idx];

  // Load a new output item this cycle
  logic emit_now;
  assign emit_now = (state == B_EMIT) && (!out_valid || !out_stall) &&
                    (op_idx != op_num) && (op != OP_CL);

  // Sequence one vertex through classification, division and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      out_valid  <= 1'b0;
      first_pend <= 1'b1;
      fcnt       <= '0;
      bcnt       <= '0;
      fside      <= '0;
      pside      <= '0;
    end else begin
      if (out_valid && !out_stall && !emit_now) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (q_valid) begin
          cur   <= q_data;
          state <= B_DECIDE;
        end
        B_DECIDE: begin
          op_idx <= '0;
          if (first_pend) begin
            fcnt <= '0; bcnt <= '0;
            fx <= cur.x; fy <= cur.y; fz <= cur.z; fside <= cur.side;
            first_pend <= cur.last;
            ops[0] <= cur.side[63] ? OP_CB : OP_CF;
            if (cur.side == 0) begin
              ops[1] <= OP_CB;
              ops[2] <= OP_ST;
              op_num <= cur.last ? 3'd3 : 3'd2;
            end else begin
              ops[1] <= OP_ST;
              op_num <= cur.last ? 3'd2 : 3'd1;
            end
            state <= B_EMIT;
          end else if (opp(cur.side, pside)) begin
            bx <= cur.x; by <= cur.y; bz <= cur.z;
            ox <= px; oy <= py; oz <= pz;
            mb <= mag64(cur.side); mo <= mag64(pside);
            if (cur.side[63]) begin
              ops[0] <= OP_IF; ops[1] <= OP_IB; ops[2] <= OP_CB;
            end else begin
              ops[0] <= OP_IB; ops[1] <= OP_IF; ops[2] <= OP_CF;
            end
            ops[3] <= OP_CL;
            op_num <= cur.last ? 3'd4 : 3'd3;
            first_pend <= cur.last;
            state <= B_SHIFT;
          end else begin
            ops[0] <= cur.side[63] ? OP_CB : OP_CF;
            if (cur.side == 0) begin
              ops[1] <= OP_CB;
              ops[2] <= OP_CL;
              op_num <= cur.last ? 3'd3 : 3'd2;
            end else begin
              ops[1] <= OP_CL;
              op_num <= cur.last ? 3'd2 : 3'd1;
            end
            first_pend <= cur.last;
            state <= B_EMIT;
          end
          px <= cur.x; py <= cur.y; pz <= cur.z; pside <= cur.side;
        end
        // Common right shift until both magnitudes fit in 31 bits
        B_SHIFT: begin
          if (mb[63:31] != 0 || mo[63:31] != 0) begin
            mb <= mb >> 1; mo <= mo >> 1;
          end else begin
            den   <= mb[31:0] + mo[31:0];
            rem   <= 63'(mb[31:1]);
            tq    <= '0;
            dcnt  <= 5'd30;
            state <= B_DIV;
          end
        end
        // Restoring division, one quotient bit per cycle
        B_DIV: begin
          logic [32:0] trial;
          logic [61:0] numer;
          numer = {mb[31:0], 30'd0};
          trial = {rem[31:0], numer[6'(dcnt)]};
          if (den == 0) begin
            tq <= '0;
            axis <= 2'd0; state <= B_MUL;
          end else begin
            if (trial >= {1'b0, den}) begin
              rem <= 63'(trial - {1'b0, den});
              tq  <= {tq[29:0], 1'b1};
            end else begin
              rem <= 63'(trial);
              tq  <= {tq[29:0], 1'b0};
            end
            if (dcnt == 0) begin
              axis <= 2'd0; state <= B_MUL;
            end
            dcnt <= dcnt - 5'd1;
          end
        end
        B_MUL: begin
          dneg  <= diff[32];
          dmag  <= diff[32] ? 33'(-diff) : 33'(diff);
          state <= B_MUL2;
        end
        B_MUL2: begin
          mprod <= 64'(dmag) * 64'(tq);
          state <= B_NEXT;
        end
        B_NEXT: begin
          case (axis)
            2'd0: ix <= rsat;
            2'd1: iy <= rsat;
            default: iz <= rsat;
          endcase
          if (axis == 2'd2) state <= B_EMIT;
          else begin
            axis  <= axis + 2'd1;
            state <= B_MUL;
          end
        end
        B_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (op_idx == op_num) begin
              state <= B_IDLE;
            end else if (op == OP_CL) begin
              // Closing edge: queue back and front intersections, or go to status
              if (opp(fside, pside)) begin
                bx <= fx; by <= fy; bz <= fz;
                ox <= px; oy <= py; oz <= pz;
                mb <= mag64(fside); mo <= mag64(pside);
                ops[op_idx]        <= OP_IB;
                ops[op_idx + 3'd1] <= OP_IF;
                ops[op_idx + 3'd2] <= OP_ST;
                op_num <= op_idx + 3'd3;
                state <= B_SHIFT;
              end else begin
                ops[op_idx] <= OP_ST;
                op_num <= op_idx + 3'd1;
              end
            end else begin
              out_valid <= 1'b1;
              case (op) inside
                OP_CF, OP_IF: begin
                  kind <= KIND_FRONT;
                  if (fcnt < Lim) fcnt <= fcnt + 1'b1;
                end
                OP_CB, OP_IB: begin
                  kind <= KIND_BACK;
                  if (bcnt < Lim) bcnt <= bcnt + 1'b1;
                end
                default: kind <= KIND_STATUS;
              endcase
              case (op) inside
                OP_CF, OP_CB: begin out_x <= cur.x; out_y <= cur.y; out_z <= cur.z; end
                OP_IF, OP_IB: begin out_x <= ix; out_y <= iy; out_z <= iz; end
                default:      begin out_x <= '0; out_y <= '0; out_z <= '0; end
              endcase
              if (op == OP_ST) begin
                front_count <= 7'(fcnt); back_count <= 7'(bcnt);
                front_kept <= (fcnt > CW'(2)); back_kept <= (bcnt > CW'(2));
                end_of_run <= 1'b1;
              end else begin
                front_count <= '0; back_count <= '0;
                front_kept  <= 1'b0; back_kept <= 1'b0; end_of_run <= 1'b0;
              end
              op_idx <= op_idx + 3'd1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^rem[62:32];

endmodule

@@ hw/rtl/polygon_plane_split.sv @@
// polygon_plane_split
// Input channel: one polygon vertex per item (vert_x/y/z Q16.16, last_vertex marks
// the end). Accepted when in_valid is high and in_stall is low.
// Output channel: front/back vertices, crossing points and one status item per
// polygon. Accepted when out_valid is high and out_stall is low.
// Config channel: cfg_valid/cfg_ready with cfg_index 0..3 = plane a, b, c, d.
// Path: the side-value accumulator runs each vertex through states F_MA to F_OUT,
// and a plain vertex then passes the queue to the splitter. A crossing adds a
// common shift, a 31-bit bit-serial divide and three multiplies (B_MUL, B_MUL2,
// B_NEXT per axis) in the splitter, and a second such run when the last vertex
// also crosses on the closing edge.
// Flow: the accumulator takes one vertex at a time; the two-entry queue
// lets the accumulator run ahead of the splitter while a crossing is resolved.
// Reset: synchronous, clears the plane to z = 0 and the queue, and waits for the
// first vertex of a polygon.
// Stall: a stalled output item holds; the splitter, then the queue, then the input
// back up.
module polygon_plane_split #(
  parameter int COUNT_LIMIT = pps_pkg::CountLimitDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vert_x,
  input  logic signed [31:0] vert_y,
  input  logic signed [31:0] vert_z,
  input  logic               last_vertex,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [6:0]         front_count,
  output logic [6:0]         back_count,
  output logic               front_kept,
  output logic               back_kept,
  output logic               end_of_run
);
  import pps_pkg::*;

  logic signed [31:0] pa, pb, pc, pd;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  vtx_t               fq_data, bq_data;

  assign cfg_ready = 1'b1;

  // Hold plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pa <= '0; pb <= '0; pc <= 32'sd65536; pd <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_A: pa <= cfg_data;
        REG_B: pb <= cfg_data;
        REG_C: pc <= cfg_data;
        REG_D: pd <= cfg_data;
        default: ;
      endcase
    end
  end

  pps_front u_front (
    .clk, .rst, .in_valid, .in_stall, .vert_x, .vert_y, .vert_z, .last_vertex,
    .pa, .pb, .pc, .pd,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  pps_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  pps_back #(.COUNT_LIMIT(COUNT_LIMIT)) u_back (
    .clk, .rst,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .out_valid, .out_stall, .kind, .out_x, .out_y, .out_z,
    .front_count, .back_count, .front_kept, .back_kept, .end_of_run
  );

endmodule

@@ verif/polygon_plane_split_tb.sv @@
`timescale 1ns / 1ps

module polygon_plane_split_tb;
  import pps_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    kind_t       kind;
    logic [31:0] x, y, z;
    logic [6:0]  fcnt, bcnt;
    logic        fkeep, bkeep, eor;
  } piece_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] vert_x = '0, vert_y = '0, vert_z = '0;
  logic last_vertex = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_A;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic signed [31:0] out_x, out_y, out_z;
  logic [6:0] front_count, back_count;
  logic front_kept, back_kept, end_of_run;

  polygon_plane_split dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Plane and split state of the golden splitter
  longint plane [4];
  vec3_t  first_pt, prev_pt;
  longint first_side, prev_side;
  int     front_n, back_n;
  bit     at_first;

  piece_t pieces_due[$];
  int     mismatches = 0;
  bit     tx_idle = 1'b1, rx_idle = 1'b1;
  int     long_hold = 0;
  int     rx_gap = 0;
  bit     took_piece = 1'b0;

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return 64'sh7fff_ffff_ffff_ffff;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic int sign_of(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic longint plane_side(vec3_t v);
    longint s;
    s = plane[0] * v[0];
    s = sat_sum(s, plane[1] * v[1]);
    s = sat_sum(s, plane[2] * v[2]);
    return sat_sum(s, plane[3] * 65536);
  endfunction

  // Crossing point from base b toward other end o
  function automatic void cross_point(vec3_t b, vec3_t o, longint fb, longint fo,
                                      output vec3_t r);
    longint unsigned mb, mo, t, den, off;
    longint diff, v;
    mb = abs64(fb);
    mo = abs64(fo);
    while (mb >= 64'h8000_0000 || mo >= 64'h8000_0000) begin
      mb = mb >> 1;
      mo = mo >> 1;
    end
    den = mb + mo;
    t = den != 0 ? (mb << 30) / den : 0;
    for (int i = 0; i < 3; i++) begin
      diff = o[i] - b[i];
      off = (abs64(diff) * t + (64'd1 << 29)) >> 30;
      v = diff < 0 ? b[i] - longint'(off) : b[i] + longint'(off);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r[i] = v;
    end
  endfunction

  function automatic void push_piece(kind_t k, vec3_t v);
    piece_t p;
    p = '{kind: k, x: v[0][31:0], y: v[1][31:0], z: v[2][31:0],
          fcnt: '0, bcnt: '0, fkeep: 1'b0, bkeep: 1'b0, eor: 1'b0};
    pieces_due.push_back(p);
    if (k == KIND_FRONT) begin
      if (front_n < CountLimitDefault) front_n++;
    end else if (back_n < CountLimitDefault) begin
      back_n++;
    end
  endfunction

  function automatic void push_sides(int s, vec3_t v);
    if (s >= 0) push_piece(KIND_FRONT, v);
    if (s <= 0) push_piece(KIND_BACK, v);
  endfunction

  // Work out the pieces that one accepted vertex yields
  function automatic void split_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic last);
    vec3_t cur, ip;
    longint f;
    piece_t p;
    cur[0] = longint'(signed'(x));
    cur[1] = longint'(signed'(y));
    cur[2] = longint'(signed'(z));
    f = plane_side(cur);
    if (at_first) begin
      front_n = 0;
      back_n = 0;
      first_pt = cur;
      first_side = f;
      push_sides(sign_of(f), cur);
      at_first = 1'b0;
    end else if (sign_of(f) * sign_of(prev_side) < 0) begin
      cross_point(cur, prev_pt, f, prev_side, ip);
      if (f > 0) begin
        push_piece(KIND_BACK, ip);
        push_piece(KIND_FRONT, ip);
        push_piece(KIND_FRONT, cur);
      end else begin
        push_piece(KIND_FRONT, ip);
        push_piece(KIND_BACK, ip);
        push_piece(KIND_BACK, cur);
      end
    end else begin
      push_sides(sign_of(f), cur);
    end
    prev_pt = cur;
    prev_side = f;
    if (last) begin
      if (sign_of(first_side) * sign_of(prev_side) < 0) begin
        cross_point(first_pt, prev_pt, first_side, prev_side, ip);
        push_piece(KIND_BACK, ip);
        push_piece(KIND_FRONT, ip);
      end
      p = '{kind: KIND_STATUS, x: '0, y: '0, z: '0,
            fcnt: front_n[6:0], bcnt: back_n[6:0],
            fkeep: front_n > 2, bkeep: back_n > 2, eor: 1'b1};
      pieces_due.push_back(p);
      at_first = 1'b1;
    end
  endfunction

  // Check each accepted output item against the oldest expected piece
  always @(posedge clk) begin
    piece_t e;
    if (!rst && out_valid && !out_stall) begin
      took_piece = 1'b1;
      if (pieces_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item kind=%0d", kind);
      end else begin
        e = pieces_due.pop_front();
        if (kind !== e.kind || out_x !== e.x || out_y !== e.y || out_z !== e.z ||
            front_count !== e.fcnt || back_count !== e.bcnt ||
            front_kept !== e.fkeep || back_kept !== e.bkeep || end_of_run !== e.eor) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("exp kind=%0d xyz=%h %h %h cnt=%0d/%0d kept=%b%b end=%b",
                     e.kind, e.x, e.y, e.z, e.fcnt, e.bcnt, e.fkeep, e.bkeep, e.eor);
            $display("got kind=%0d xyz=%h %h %h cnt=%0d/%0d kept=%b%b end=%b",
                     kind, out_x, out_y, out_z, front_count, back_count,
                     front_kept, back_kept, end_of_run);
          end
        end
      end
    end
  end

  // Drive output stall: long hold first, then per-item random gaps
  always @(negedge clk) begin
    if (took_piece) begin
      rx_gap = rx_idle ? $urandom_range(0, 6) : 0;
      took_piece = 1'b0;
    end
    if (long_hold > 0) begin
      out_stall = 1'b1;
      long_hold--;
    end else if (rx_gap > 0) begin
      out_stall = 1'b1;
      rx_gap--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    vert_x = x;
    vert_y = y;
    vert_z = z;
    last_vertex = last;
    do @(posedge clk); while (in_stall);
    split_vertex(x, y, z, last);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the sender until every piece is back, then let the splitter settle
  task automatic drain();
    drop_valid();
    while (pieces_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_plane(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    plane[idx] = longint'(signed'(data));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_plane(REG_A, a);
    write_plane(REG_B, b);
    write_plane(REG_C, c);
    write_plane(REG_D, d);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  function automatic logic [31:0] rand_plane_term();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return $urandom;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  function automatic logic [31:0] q16(int v);
    return v <<< 16;
  endfunction

  // Default plane z = 0: vertex on plane, crossing triangle, closing-edge crossing
  task automatic test_reset_plane();
    send_vertex(q16(3), q16(4), 32'h0, 1'b1);
    send_vertex(0, 0, q16(-1), 1'b0);
    send_vertex(q16(1), 0, q16(1), 1'b0);
    send_vertex(0, q16(1), q16(3), 1'b1);
    send_vertex(0, 0, q16(2), 1'b0);
    send_vertex(q16(1), 0, q16(1), 1'b0);
    send_vertex(q16(2), q16(2), q16(-2), 1'b1);
    drain();
  endtask

  // Field extremes with saturating side values and clipped crossings
  task automatic test_extremes();
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 1'b1);
    drain();
    set_plane(32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(q16(1), q16(2), q16(3), 1'b0);
    send_vertex(q16(5), q16(6), q16(7), 1'b1);
    drain();
    set_plane(32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, q16(1), 0, 1'b0);
    send_vertex(32'h7fff_ffff, q16(2), 0, 1'b0);
    send_vertex(32'h0001_0000, 0, 0, 1'b0);
    send_vertex(32'h8000_0000, 0, q16(9), 1'b1);
    drain();
  endtask

  // Alternating sides push both counters past their limit
  task automatic test_count_limit();
    set_plane(0, 0, q16(1), 0);
    for (int i = 0; i < 90; i++)
      send_vertex($urandom_range(0, 1 << 20), $urandom, i[0] ? q16(1) : q16(-1), i == 89);
    drain();
  endtask

  // Hold the output for a long stretch while vertices keep coming
  task automatic test_backpressure();
    tx_idle = 1'b0;
    long_hold = 400;
    for (int i = 0; i < 12; i++)
      send_vertex(rand_coord(), rand_coord(), $urandom_range(0, 1 << 20) - (1 << 19),
                  i == 11);
    tx_idle = 1'b1;
    drain();
  endtask

  // Random planes and polygons, with idle patterns varied per phase
  task automatic test_random_polygons();
    int sent, nv;
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      set_plane(rand_plane_term(), rand_plane_term(), rand_plane_term(), rand_plane_term());
      tx_idle = ph % 3 != 1;
      rx_idle = ph % 4 != 2;
      for (int k = 0; k < 20 / 4 + 1 && sent < 160; k++) begin
        nv = $urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 7);
        for (int i = 0; i < nv; i++) begin
          send_vertex(rand_coord(), rand_coord(), rand_coord(), i == nv - 1);
          sent++;
        end
      end
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    plane = '{0, 0, 65536, 0};
    first_pt = '{0, 0, 0};
    prev_pt = '{0, 0, 0};
    first_side = 0;
    prev_side = 0;
    front_n = 0;
    back_n = 0;
    at_first = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_plane();
    test_extremes();
    test_count_limit();
    test_backpressure();
    test_random_polygons();
    drain();
    if (mismatches == 0 && pieces_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pps_pkg.sv
hw/rtl/pps_front.sv
hw/rtl/pps_queue.sv
hw/rtl/pps_back.sv
hw/rtl/polygon_plane_split.sv
verif/polygon_plane_split_tb.sv
